// File: hdl/imrot_pkg.sv
// Shared types and constants for the quarter-turn image rotation address generator.
package imrot_pkg;

	localparam int MAX_DIM_DEF   = 4096;
	localparam int ADDR_BITS_DEF = 26;

	localparam int PIXEL_W     = 32;
	localparam int BPP_W       = 3;
	localparam int DIM_W       = 13;
	localparam int STRIDE_W    = 15;
	localparam int CFG_DATA_W  = 15;
	localparam int CFG_INDEX_W = 3;

	localparam logic [BPP_W-1:0]    BPP_RESET    = 3'd2;
	localparam logic [DIM_W-1:0]    DIM_RESET    = 13'd1;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 15'd4;
	localparam logic [BPP_W-1:0]    BPP_MAX      = 3'd4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROTATION = 3'd0,
		REG_BPP      = 3'd1,
		REG_WIDTH    = 3'd2,
		REG_HEIGHT   = 3'd3,
		REG_STRIDE   = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic                ccw;
		logic [BPP_W-1:0]    bpp;
		logic [STRIDE_W-1:0] stride;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
	} geom_t;

endpackage

// File: hdl/imrot_cfg.sv
// Configuration registers with clamped geometry and the precomputed image start offset.
module imrot_cfg #(
	parameter int MAX_DIM   = imrot_pkg::MAX_DIM_DEF,
	parameter int ADDR_BITS = imrot_pkg::ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [imrot_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [imrot_pkg::CFG_DATA_W-1:0]    cfg_data,
	output imrot_pkg::geom_t                    geom,
	output logic [ADDR_BITS-1:0]                start_addr,
	output logic                                busy
);

	localparam int PROD_W = imrot_pkg::DIM_W + imrot_pkg::STRIDE_W;

	logic                              rotation_q;
	logic [imrot_pkg::BPP_W-1:0]       bpp_q;
	logic [imrot_pkg::DIM_W-1:0]       width_q;
	logic [imrot_pkg::DIM_W-1:0]       height_q;
	logic [imrot_pkg::STRIDE_W-1:0]    stride_q;

	imrot_pkg::geom_t                  geom_c;
	imrot_pkg::geom_t                  geom_q;
	logic [imrot_pkg::DIM_W-1:0]       mul_a;
	logic [imrot_pkg::STRIDE_W-1:0]    mul_b;
	logic [PROD_W-1:0]                 prod;
	logic [ADDR_BITS-1:0]              start_q;
	logic                              busy_q;

	function automatic logic [imrot_pkg::DIM_W-1:0] clamp_dim(
		input logic [imrot_pkg::DIM_W-1:0] v
	);
		logic [imrot_pkg::DIM_W-1:0] r;
		if (v == '0) begin
			r = imrot_pkg::DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = imrot_pkg::DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 1'b0;
			bpp_q      <= imrot_pkg::BPP_RESET;
			width_q    <= imrot_pkg::DIM_RESET;
			height_q   <= imrot_pkg::DIM_RESET;
			stride_q   <= imrot_pkg::STRIDE_RESET;
		end else if (cfg_write) begin
			unique case (imrot_pkg::reg_index_t'(cfg_index))
				imrot_pkg::REG_ROTATION: rotation_q <= cfg_data[0];
				imrot_pkg::REG_BPP:      bpp_q      <= cfg_data[imrot_pkg::BPP_W-1:0];
				imrot_pkg::REG_WIDTH:    width_q    <= cfg_data[imrot_pkg::DIM_W-1:0];
				imrot_pkg::REG_HEIGHT:   height_q   <= cfg_data[imrot_pkg::DIM_W-1:0];
				imrot_pkg::REG_STRIDE:   stride_q   <= cfg_data[imrot_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		geom_c.ccw    = rotation_q;
		geom_c.stride = stride_q;
		geom_c.width  = clamp_dim(width_q);
		geom_c.height = clamp_dim(height_q);
		if (bpp_q == '0) begin
			geom_c.bpp = imrot_pkg::BPP_W'(1);
		end else if (bpp_q > imrot_pkg::BPP_MAX) begin
			geom_c.bpp = imrot_pkg::BPP_MAX;
		end else begin
			geom_c.bpp = bpp_q;
		end
		// The first pixel lands at the last target row for 270 degrees, or the last
		// target column for 90 degrees.
		if (geom_c.ccw) begin
			mul_a = geom_c.width - imrot_pkg::DIM_W'(1);
			mul_b = geom_c.stride;
		end else begin
			mul_a = geom_c.height - imrot_pkg::DIM_W'(1);
			mul_b = imrot_pkg::STRIDE_W'(geom_c.bpp);
		end
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.ccw    <= 1'b0;
			geom_q.bpp    <= imrot_pkg::BPP_RESET;
			geom_q.stride <= imrot_pkg::STRIDE_RESET;
			geom_q.width  <= imrot_pkg::DIM_RESET;
			geom_q.height <= imrot_pkg::DIM_RESET;
			start_q       <= '0;
			busy_q        <= 1'b0;
		end else begin
			geom_q  <= geom_c;
			start_q <= ADDR_BITS'(prod);
			busy_q  <= cfg_write;
		end
	end

	assign geom       = geom_q;
	assign start_addr = start_q;
	assign busy       = busy_q;

endmodule

// File: hdl/imrot_addr_gen.sv
// Column and row counters with running target offset adders.
module imrot_addr_gen #(
	parameter int MAX_DIM   = imrot_pkg::MAX_DIM_DEF,
	parameter int ADDR_BITS = imrot_pkg::ADDR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  imrot_pkg::geom_t       geom,
	input  logic [ADDR_BITS-1:0]   start_addr,
	output logic [ADDR_BITS-1:0]   offset,
	output logic                   last
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int CMP_W = (CNT_W + 1 > imrot_pkg::DIM_W) ? CNT_W + 1 : imrot_pkg::DIM_W;

	logic [CNT_W-1:0]     col_q;
	logic [CNT_W-1:0]     row_q;
	logic [ADDR_BITS-1:0] row_start_q;
	logic [ADDR_BITS-1:0] cur_q;

	logic                 first;
	logic [ADDR_BITS-1:0] base_row;
	logic [ADDR_BITS-1:0] base_cur;
	logic [ADDR_BITS-1:0] bpp_ext;
	logic [ADDR_BITS-1:0] stride_ext;
	logic [ADDR_BITS-1:0] next_row_start;
	logic [ADDR_BITS-1:0] next_cur;
	logic                 row_end;
	logic                 img_end;

	always_comb begin
		first      = (col_q == '0) && (row_q == '0);
		base_row   = first ? start_addr : row_start_q;
		base_cur   = first ? start_addr : cur_q;
		bpp_ext    = ADDR_BITS'(geom.bpp);
		stride_ext = ADDR_BITS'(geom.stride);
		row_end    = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(geom.width);
		img_end    = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(geom.height);
		next_row_start = geom.ccw ? base_row + bpp_ext : base_row - bpp_ext;
		next_cur       = geom.ccw ? base_cur - stride_ext : base_cur + stride_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			row_start_q <= '0;
			cur_q       <= '0;
		end else if (step) begin
			if (row_end) begin
				col_q       <= '0;
				row_start_q <= next_row_start;
				cur_q       <= next_row_start;
				row_q       <= img_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q       <= col_q + CNT_W'(1);
				row_start_q <= base_row;
				cur_q       <= next_cur;
			end
		end
	end

	assign offset = base_cur;
	assign last   = row_end && img_end;

endmodule

// File: hdl/image_rotate_quarter_turn_addr.sv
// Top level of the quarter-turn image rotation address generator.
// Source pixels enter on the in channel (in_valid, in_ready, pixel) in raster order.
// Each pixel leaves on the out channel (out_valid, out_ready) with target_offset,
// the byte offset in the rotated target image, pixel_out and last_pixel, which
// marks the final pixel of the image. Offsets follow from running adders over the
// column and row counters; the counters return to zero after the last pixel.
// An accepted pixel is registered into the output stage, or the skid register on a stall;
// one pixel can be taken every cycle while in_ready is high.
// The user must write registers through cfg_write, cfg_index and cfg_data while the
// block is idle; the block itself does not enforce this. In the cycle after a write,
// in_ready is low while the clamped geometry and the image start offset are recomputed.
// Reset clears the counters and the output stages and loads the register defaults.
// When the receiver stalls, one more transaction is held in a skid register; after
// that in_ready falls until the output drains.
module image_rotate_quarter_turn_addr #(
	parameter int MAX_DIM   = imrot_pkg::MAX_DIM_DEF,
	parameter int ADDR_BITS = imrot_pkg::ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [imrot_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [imrot_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [imrot_pkg::PIXEL_W-1:0]       pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ADDR_BITS-1:0]                target_offset,
	output logic [imrot_pkg::PIXEL_W-1:0]       pixel_out,
	output logic                                last_pixel
);

	imrot_pkg::geom_t                 geom;
	logic [ADDR_BITS-1:0]             start_addr;
	logic                             cfg_busy;
	logic [ADDR_BITS-1:0]             gen_offset;
	logic                             gen_last;
	logic                             accept;

	logic                             out_valid_q;
	logic [ADDR_BITS-1:0]             out_offset_q;
	logic [imrot_pkg::PIXEL_W-1:0]    out_pixel_q;
	logic                             out_last_q;
	logic                             skid_valid_q;
	logic [ADDR_BITS-1:0]             skid_offset_q;
	logic [imrot_pkg::PIXEL_W-1:0]    skid_pixel_q;
	logic                             skid_last_q;

	imrot_cfg #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.geom       (geom),
		.start_addr (start_addr),
		.busy       (cfg_busy)
	);

	imrot_addr_gen #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_addr_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.geom       (geom),
		.start_addr (start_addr),
		.offset     (gen_offset),
		.last       (gen_last)
	);

	assign in_ready = !skid_valid_q && !cfg_busy;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_offset_q <= skid_offset_q;
				out_pixel_q  <= skid_pixel_q;
				out_last_q   <= skid_last_q;
			end else begin
				out_offset_q <= gen_offset;
				out_pixel_q  <= pixel;
				out_last_q   <= gen_last;
			end
		end else if (accept) begin
			skid_offset_q <= gen_offset;
			skid_pixel_q  <= pixel;
			skid_last_q   <= gen_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign target_offset = out_offset_q;
	assign pixel_out     = out_pixel_q;
	assign last_pixel    = out_last_q;

	a_cfg_blocks_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> !(in_valid && in_ready))
		else $error("Input transaction accepted right after a register write.");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid register holds a transaction while the output is empty.");

	a_full_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && skid_valid_q) |=> (out_valid_q && skid_valid_q))
		else $error("Buffered transaction lost while the receiver stalls.");

endmodule

// File: tb/imrot_placement_check.sv
// Checker for the rotation address generator: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module imrot_placement_check #(
	parameter int MAX_DIM   = imrot_pkg::MAX_DIM_DEF,
	parameter int ADDR_BITS = imrot_pkg::ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [imrot_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [imrot_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [imrot_pkg::PIXEL_W-1:0]       pixel,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [ADDR_BITS-1:0]                target_offset,
	input  logic [imrot_pkg::PIXEL_W-1:0]       pixel_out,
	input  logic                                last_pixel,
	output int                                  pending,
	output int                                  errors
);

	typedef struct packed {
		logic [ADDR_BITS-1:0]          offset;
		logic [imrot_pkg::PIXEL_W-1:0] value;
		logic                          last;
	} placed_t;

	logic                           rot_ccw;
	logic [imrot_pkg::BPP_W-1:0]    bpp_reg;
	logic [imrot_pkg::DIM_W-1:0]    width_reg;
	logic [imrot_pkg::DIM_W-1:0]    height_reg;
	logic [imrot_pkg::STRIDE_W-1:0] stride_reg;

	logic [11:0]          col_cnt;
	logic [11:0]          row_cnt;
	logic [ADDR_BITS-1:0] row_base;
	logic [ADDR_BITS-1:0] next_offset;

	placed_t placed_q[$];

	function automatic int unsigned clamp_dim(input logic [imrot_pkg::DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return 32'(v);
	endfunction

	// Works out where a source pixel lands and moves the raster counters on.
	function automatic placed_t place_pixel(input logic [imrot_pkg::PIXEL_W-1:0] value);
		int unsigned          w;
		int unsigned          h;
		int unsigned          b;
		logic [ADDR_BITS-1:0] step_b;
		logic [ADDR_BITS-1:0] step_s;
		logic [ADDR_BITS-1:0] span;
		placed_t              r;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		b = (bpp_reg == 0) ? 1 :
			((bpp_reg > imrot_pkg::BPP_MAX) ? 32'(imrot_pkg::BPP_MAX) : 32'(bpp_reg));
		step_b = ADDR_BITS'(b);
		step_s = ADDR_BITS'(stride_reg);
		if (col_cnt == 0 && row_cnt == 0) begin
			if (rot_ccw)
				span = ADDR_BITS'((w - 1) * 32'(stride_reg));
			else
				span = ADDR_BITS'((h - 1) * b);
			row_base = span;
			next_offset = span;
		end
		r.offset = next_offset;
		r.value = value;
		r.last = 1'b0;
		if (32'(col_cnt) + 1 >= w) begin
			col_cnt = '0;
			row_base = rot_ccw ? row_base + step_b : row_base - step_b;
			next_offset = row_base;
			if (32'(row_cnt) + 1 >= h) begin
				r.last = 1'b1;
				row_cnt = '0;
			end else begin
				row_cnt = row_cnt + 1'b1;
			end
		end else begin
			col_cnt = col_cnt + 1'b1;
			next_offset = rot_ccw ? next_offset - step_s : next_offset + step_s;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placed_t want;
		if (!arst_n) begin
			rot_ccw = 1'b0;
			bpp_reg = imrot_pkg::BPP_RESET;
			width_reg = imrot_pkg::DIM_RESET;
			height_reg = imrot_pkg::DIM_RESET;
			stride_reg = imrot_pkg::STRIDE_RESET;
			col_cnt = '0;
			row_cnt = '0;
			row_base = '0;
			next_offset = '0;
			placed_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					imrot_pkg::REG_ROTATION: rot_ccw = cfg_data[0];
					imrot_pkg::REG_BPP:      bpp_reg = cfg_data[imrot_pkg::BPP_W-1:0];
					imrot_pkg::REG_WIDTH:    width_reg = cfg_data[imrot_pkg::DIM_W-1:0];
					imrot_pkg::REG_HEIGHT:   height_reg = cfg_data[imrot_pkg::DIM_W-1:0];
					imrot_pkg::REG_STRIDE:   stride_reg = cfg_data[imrot_pkg::STRIDE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (placed_q.size() == 0) begin
					$error("unexpected result: target_offset %0h pixel_out %0h last_pixel %0b",
						target_offset, pixel_out, last_pixel);
					errors++;
				end else begin
					want = placed_q.pop_front();
					if (target_offset !== want.offset) begin
						$error("target_offset: expected %0h, got %0h", want.offset, target_offset);
						errors++;
					end
					if (pixel_out !== want.value) begin
						$error("pixel_out: expected %0h, got %0h", want.value, pixel_out);
						errors++;
					end
					if (last_pixel !== want.last) begin
						$error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				placed_q.push_back(place_pixel(pixel));
			pending <= placed_q.size();
		end
	end

endmodule

// File: tb/tb.sv
// Testbench top for the rotation address generator: stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int ADDR_BITS = imrot_pkg::ADDR_BITS_DEF;
	localparam int ITEMS     = 750;
	localparam int LIMIT     = 400000;
	localparam logic [imrot_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_write = 1'b0;
	logic [imrot_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [imrot_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [imrot_pkg::PIXEL_W-1:0]     pixel = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [ADDR_BITS-1:0]              target_offset;
	logic [imrot_pkg::PIXEL_W-1:0]     pixel_out;
	logic                              last_pixel;

	int pending;
	int errors;
	int cycles = 0;
	int n_sent = 0;
	int n_images = 0;
	int n_phases = 0;
	logic quiet = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	image_rotate_quarter_turn_addr u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target_offset(target_offset),
		.pixel_out(pixel_out),
		.last_pixel(last_pixel)
	);

	imrot_placement_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target_offset(target_offset),
		.pixel_out(pixel_out),
		.last_pixel(last_pixel),
		.pending(pending),
		.errors(errors)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// The receiver counts out a long hold-off on its own whenever a new one is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 120;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 21);
		end
	end

	always @(posedge clk)
		if (out_valid && out_ready && last_pixel)
			n_images++;

	task automatic write_reg(input logic [imrot_pkg::CFG_INDEX_W-1:0] idx,
		input logic [imrot_pkg::CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic rot, input logic [imrot_pkg::CFG_DATA_W-1:0] bpp,
		input logic [imrot_pkg::CFG_DATA_W-1:0] w, input logic [imrot_pkg::CFG_DATA_W-1:0] h,
		input logic [imrot_pkg::CFG_DATA_W-1:0] stride);
		write_reg(imrot_pkg::REG_ROTATION, imrot_pkg::CFG_DATA_W'(rot));
		write_reg(imrot_pkg::REG_BPP, bpp);
		write_reg(imrot_pkg::REG_WIDTH, w);
		write_reg(imrot_pkg::REG_HEIGHT, h);
		write_reg(imrot_pkg::REG_STRIDE, stride);
		cfg_write <= 1'b0;
	endtask

	task automatic send_pixel(input logic [imrot_pkg::PIXEL_W-1:0] v);
		while (!quiet && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [imrot_pkg::PIXEL_W-1:0] any_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [imrot_pkg::CFG_DATA_W-1:0] any_dim();
		case ($urandom_range(9))
			0: return '0;
			1: return imrot_pkg::CFG_DATA_W'(imrot_pkg::MAX_DIM_DEF);
			2: return imrot_pkg::CFG_DATA_W'($urandom_range(8191, imrot_pkg::MAX_DIM_DEF + 1));
			default: return imrot_pkg::CFG_DATA_W'($urandom_range(8, 1));
		endcase
	endfunction

	function automatic logic [imrot_pkg::CFG_DATA_W-1:0] any_stride();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return imrot_pkg::CFG_DATA_W'($urandom_range(32767));
			default: return imrot_pkg::CFG_DATA_W'($urandom_range(64, 1));
		endcase
	endfunction

	initial begin
		int batch;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: a one-pixel image, so every pixel is the last one.
		send_pixel('0);
		send_pixel('1);
		wait_drain();

		set_geometry(1'b0, 15'd3, 15'd3, 15'd2, 15'd10);
		repeat (6) send_pixel(any_pixel());
		wait_drain();
		write_reg(imrot_pkg::REG_ROTATION, 15'd1);
		cfg_write <= 1'b0;
		repeat (6) send_pixel(any_pixel());
		wait_drain();

		// Out-of-range sizes, a zero stride and a write to an unused index.
		write_reg(REG_SPARE, '1);
		set_geometry(1'b0, 15'd0, 15'd0, 15'd0, 15'd0);
		repeat (2) send_pixel(any_pixel());
		wait_drain();
		set_geometry(1'b1, 15'd7, 15'd8191, 15'd8191, 15'h7FFF);
		repeat (4) send_pixel(any_pixel());
		wait_drain();

		// Shrinking the image mid-row makes the column count pass the width.
		write_reg(imrot_pkg::REG_WIDTH, 15'd2);
		write_reg(imrot_pkg::REG_HEIGHT, 15'd1);
		cfg_write <= 1'b0;
		repeat (2) send_pixel(any_pixel());
		wait_drain();
		set_geometry(1'b0, 15'd4, 15'(imrot_pkg::MAX_DIM_DEF), 15'(imrot_pkg::MAX_DIM_DEF),
			15'd16384);
		repeat (3) send_pixel(any_pixel());
		wait_drain();
		write_reg(imrot_pkg::REG_WIDTH, 15'd1);
		write_reg(imrot_pkg::REG_HEIGHT, 15'd1);
		cfg_write <= 1'b0;
		send_pixel(any_pixel());
		wait_drain();

		while (n_sent < ITEMS) begin
			if ($urandom_range(3) != 0)
				write_reg(imrot_pkg::REG_ROTATION, imrot_pkg::CFG_DATA_W'($urandom_range(1)));
			if ($urandom_range(3) != 0)
				write_reg(imrot_pkg::REG_BPP, imrot_pkg::CFG_DATA_W'($urandom_range(7)));
			if ($urandom_range(3) != 0)
				write_reg(imrot_pkg::REG_WIDTH, any_dim());
			if ($urandom_range(3) != 0)
				write_reg(imrot_pkg::REG_HEIGHT, any_dim());
			if ($urandom_range(3) != 0)
				write_reg(imrot_pkg::REG_STRIDE, any_stride());
			cfg_write <= 1'b0;
			if (n_phases == 4)
				hold_req <= hold_req + 1;
			quiet <= (n_phases >= 8 && n_phases < 12);
			batch = $urandom_range(50, 10);
			repeat (batch) send_pixel(any_pixel());
			wait_drain();
			n_phases++;
		end

		quiet <= 1'b0;
		repeat (8) @(posedge clk);
		$display("Sent %0d pixels over %0d random register phases; %0d images completed.",
			n_sent, n_phases, n_images);
		$display("Run included a long output hold-off and a stretch with no idle cycles.");
		if (errors == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/imrot_pkg.sv
hdl/imrot_cfg.sv
hdl/imrot_addr_gen.sv
hdl/image_rotate_quarter_turn_addr.sv
tb/imrot_placement_check.sv
tb/tb.sv
